FILE: rtl/bpv_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bpv_pkg: shared types and constants
// Widths, payload structs and state encodings for the brush plane vertex
// enumerator and its cells.
// ---------------------------------------------------------------------------
package bpv_pkg;

   localparam int MAX_SIDES  = 16;
   localparam int MAX_VERTS  = 63;
   localparam int MIN_PLANES = 3;

   localparam int IDX_W  = $clog2(MAX_SIDES);
   localparam int CNT_W  = $clog2(MAX_SIDES + 1);
   localparam int VCNT_W = 6;

   localparam int NRM_W  = 17;   // reordered normal, -y needs one more bit
   localparam int DST_W  = 32;   // scaled distance, Q.8
   localparam int CRS_W  = 35;   // cross product component, Q.28
   localparam int QTR_W  = 33;   // cross component / 4
   localparam int DET_W  = 54;   // determinant, Q.42
   localparam int NUM_W  = 64;   // numerator, wraps like 64-bit math
   localparam int PNT_W  = 24;   // point, Q15.8
   localparam int PRD_W  = 41;   // normal * point
   localparam int DOT_W  = 49;   // signed distance to plane, Q.22
   localparam int TOL_W  = 27;
   localparam int SCL_W  = 16;

   localparam int QUOT_W    = 24;
   localparam int INT_STEPS = 8;
   localparam int DSH_W     = DET_W + INT_STEPS - 1;

   localparam logic [DET_W-1:0]  EPS_Q42  = DET_W'(4398047);
   localparam logic [SCL_W-1:0]  SCALE_RST = SCL_W'(256);
   localparam logic [QUOT_W-1:0] SAT_NEG  = QUOT_W'(8388608);
   localparam logic [QUOT_W-1:0] SAT_POS  = QUOT_W'(8388607);

   typedef struct packed {
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic signed [23:0] plane_dist;
      logic               last_plane;
   } req_type;

   typedef struct packed {
      logic signed [23:0] vert_x;
      logic signed [23:0] vert_y;
      logic signed [23:0] vert_z;
      logic               is_vertex;
      logic [5:0]         vertex_count;
      logic               overflow;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [2:0][NRM_W-1:0] nrm;
      logic [DST_W-1:0]      dst;
   } plane_type;

   // point travelling down the cell chain
   typedef struct packed {
      logic                  valid;
      logic                  outside;
      logic [2:0][PNT_W-1:0] p;
   } point_type;

   // triple under test, constant during a scan
   typedef struct packed {
      logic [IDX_W-1:0] i;
      logic [IDX_W-1:0] j;
      logic [IDX_W-1:0] k;
      logic [CNT_W-1:0] n;
      logic [TOL_W-1:0] tol;
   } scan_ctl_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
   } div_res_type;

   typedef enum logic {
      DIV_IDLE,
      DIV_RUN
   } div_st_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_FI,
      ST_FJ,
      ST_FK,
      ST_CR,
      ST_DET,
      ST_CHK,
      ST_NUM,
      ST_DSTART,
      ST_DWAIT,
      ST_SCAN_GO,
      ST_SCAN_WAIT,
      ST_EMIT,
      ST_NEXT,
      ST_CLOSE
   } st_type;

endpackage

FILE: rtl/bpv_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bpv_cell: one plane slot of the chain
// Holds one plane and tests the passing point against it, two stages deep.
// ---------------------------------------------------------------------------
module bpv_cell
   import bpv_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] cell_idx,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  plane_type        wr_plane,
   input  scan_ctl_type     ctl,
   input  point_type        pt_in,
   output point_type        pt_out,
   output plane_type        plane_out
);

   plane_type                    plane_ff;
   logic                         v1_ff, v1_in;
   logic                         out1_ff;
   logic [2:0][PNT_W-1:0]        p1_ff;
   logic signed [2:0][PRD_W-1:0] prod_ff, prod_in;
   point_type                    pt_ff, pt_in_nx;
   logic                         active;
   logic signed [DOT_W-1:0]      dot;

   always_comb begin
      for (int t = 0; t < 3; t++) begin
         prod_in[t] = $signed(plane_ff.nrm[t]) * $signed(pt_in.p[t]);
      end
      v1_in  = pt_in.valid;
      active = (CNT_W'(cell_idx) < ctl.n) && (cell_idx != ctl.i)
               && (cell_idx != ctl.j) && (cell_idx != ctl.k);
      dot = DOT_W'($signed(prod_ff[0])) + DOT_W'($signed(prod_ff[1]))
            + DOT_W'($signed(prod_ff[2]))
            - DOT_W'($signed({plane_ff.dst, 14'b0}));
      pt_in_nx.valid   = v1_ff;
      pt_in_nx.outside = out1_ff || (active && (dot > $signed({22'b0, ctl.tol})));
      pt_in_nx.p       = p1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff       <= 1'b0;
         pt_ff.valid <= 1'b0;
      end else begin
         v1_ff       <= v1_in;
         pt_ff.valid <= pt_in_nx.valid;
      end
      out1_ff       <= pt_in.outside;
      p1_ff         <= pt_in.p;
      prod_ff       <= prod_in;
      pt_ff.outside <= pt_in_nx.outside;
      pt_ff.p       <= pt_in_nx.p;
      if (wr_en && (wr_idx == cell_idx)) begin
         plane_ff <= wr_plane;
      end
   end

   assign pt_out    = pt_ff;
   assign plane_out = plane_ff;

endmodule

FILE: rtl/bpv_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bpv_div: saturating restoring divider
// Computes floor(dividend * 2^16 / divisor), one quotient bit a cycle;
// quotients of 256 or more in the integer part report 2^23.
// ---------------------------------------------------------------------------
module bpv_div
   import bpv_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DET_W-1:0] divisor,
   output div_res_type      res
);

   div_st_type        st_ff, st_in;
   logic [NUM_W:0]    r_ff, r_in;
   logic [DSH_W-1:0]  dsh_ff, dsh_in;
   logic [4:0]        step_ff, step_in;
   logic [QUOT_W-1:0] q_ff, q_in;
   logic              done_ff, done_in;
   logic [NUM_W:0]    trial;
   logic              fits;

   always_comb begin
      st_in   = st_ff;
      r_in    = r_ff;
      dsh_in  = dsh_ff;
      step_in = step_ff;
      q_in    = q_ff;
      done_in = 1'b0;
      trial   = (step_ff < 5'(INT_STEPS)) ? r_ff : {r_ff[NUM_W-1:0], 1'b0};
      fits    = trial >= (NUM_W + 1)'(dsh_ff);
      case (st_ff)
         DIV_IDLE: begin
            if (start) begin
               if (dividend >= NUM_W'({divisor, 8'b0})) begin
                  q_in    = SAT_NEG;
                  done_in = 1'b1;
               end else begin
                  r_in    = {1'b0, dividend};
                  dsh_in  = {divisor, 7'b0};
                  step_in = '0;
                  q_in    = '0;
                  st_in   = DIV_RUN;
               end
            end
         end
         DIV_RUN: begin
            r_in = fits ? trial - (NUM_W + 1)'(dsh_ff) : trial;
            q_in = {q_ff[QUOT_W-2:0], fits};
            if (step_ff < 5'(INT_STEPS - 1)) begin
               dsh_in = dsh_ff >> 1;
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(QUOT_W - 1)) begin
               done_in = 1'b1;
               st_in   = DIV_IDLE;
            end
         end
         default: st_in = DIV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= DIV_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff    <= r_in;
      dsh_ff  <= dsh_in;
      step_ff <= step_in;
      q_ff    <= q_in;
   end

   assign res.done = done_ff;
   assign res.quot = q_ff;

endmodule

FILE: rtl/brush_plane_vertex_enumerator_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// brush_plane_vertex_enumerator_core: convex brush vertex finder
// Loads brush planes, intersects every plane triple and emits the corners.
// ---------------------------------------------------------------------------
// Usage:
//  - req_* carries one plane per transfer (normal Q1.14, distance Q15.8).
//    Planes are taken while idle; up to MAX_SIDES planes are kept,
//    extra ones are dropped. last_plane = 1 starts the solve.
//  - During the solve req_stall stays high. Each triple i<j<k fetches one to
//    three planes, forms the cross product and determinant, then per axis
//    forms a numerator and runs the divider (cut short if saturated), then
//    walks the point through the cell chain for the inside test, emits it
//    if inside and room remains, and advances. Singular triples leave after
//    the determinant. The single divider and the chain walk take most of the
//    time per triple.
//  - rsp_* carries vertices in triple order, then one closing transfer
//    with last = 1, the count and the overflow flag.
//  - rsp has an output register; when the receiver stalls, the solve
//    waits at the next vertex or closing item until the register drains.
//  - csr_wr_en/csr_wr_data write the Q8.8 scale; write only while idle.
//  - reset (synchronous) empties the plane set, drops any pending result
//    and sets scale to 1.0.
// ---------------------------------------------------------------------------
module brush_plane_vertex_enumerator_core
   import bpv_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [SCL_W-1:0] csr_wr_data
);

   typedef logic [2:0][CRS_W-1:0] crs_vec_type;

   // cross product of two reordered normals, exact in Q.28
   function automatic crs_vec_type cross3(logic [2:0][NRM_W-1:0] a,
                                          logic [2:0][NRM_W-1:0] b);
      logic signed [2*NRM_W-1:0] p1, p2;
      crs_vec_type c;
      for (int t = 0; t < 3; t++) begin
         p1 = $signed(a[(t + 1) % 3]) * $signed(b[(t + 2) % 3]);
         p2 = $signed(a[(t + 2) % 3]) * $signed(b[(t + 1) % 3]);
         c[t] = {p1[2*NRM_W-1], p1} - {p2[2*NRM_W-1], p2};
      end
      return c;
   endfunction

   // division by 4, truncated toward zero
   function automatic logic [QTR_W-1:0] quarter(logic [CRS_W-1:0] c);
      logic [CRS_W-1:0] adj;
      adj = c[CRS_W-1] ? c + CRS_W'(3) : c;
      return adj[CRS_W-1:2];
   endfunction

   st_type            state_ff, state_in;
   logic [SCL_W-1:0]  scale_ff;
   logic [62:0]       tol_prod_ff;
   logic [TOL_W-1:0]  tol_ff;
   logic [CNT_W-1:0]  plane_cnt_ff, plane_cnt_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [IDX_W-1:0]  i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [VCNT_W-1:0] emit_cnt_ff, emit_cnt_in;
   logic              ovf_ff, ovf_in;
   plane_type         a_ff, a_in, b_ff, b_in, c_ff, c_in;
   crs_vec_type       c23_ff, c23_in, c31_ff, c31_in, c12_ff, c12_in;
   logic [DET_W-1:0]  det_ff, det_in;
   logic [1:0]        t_ff, t_in;
   logic [NUM_W-1:0]  un_ff, un_in;
   logic              neg_ff, neg_in;
   logic [2:0][PNT_W-1:0] p_ff, p_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              req_xfer, out_free, div_start, wr_en;
   logic [IDX_W-1:0]  rd_idx;
   plane_type         wr_plane, rd_plane;
   plane_type         cell_plane [MAX_SIDES];
   point_type         chain [MAX_SIDES];
   point_type         inject;
   scan_ctl_type      ctl;
   div_res_type       div_res;
   logic [DET_W-1:0]  det_mag;
   logic [QUOT_W-1:0] q_clamp;

   // combinational helpers
   logic signed [40:0]        dprod;
   logic [40:0]               dmag;
   logic [32:0]               drnd;
   logic signed [NRM_W+CRS_W-1:0] dt0, dt1, dt2;
   logic signed [NUM_W-1:0]   n0, n1, n2, num;

   assign req_xfer  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rd_plane  = cell_plane[rd_idx];
   assign det_mag   = det_ff[DET_W-1] ? -det_ff : det_ff;

   assign ctl.i   = i_ff;
   assign ctl.j   = j_ff;
   assign ctl.k   = k_ff;
   assign ctl.n   = n_ff;
   assign ctl.tol = tol_ff;

   // plane load: reorder to (x, z, -y), scale and round the distance
   always_comb begin
      wr_plane.nrm[0] = {req_data.normal_x[15], req_data.normal_x};
      wr_plane.nrm[1] = {req_data.normal_z[15], req_data.normal_z};
      wr_plane.nrm[2] = -{req_data.normal_y[15], req_data.normal_y};
      dprod = req_data.plane_dist * $signed({1'b0, scale_ff});
      dmag  = dprod[40] ? -dprod : dprod;
      drnd  = 33'((dmag + 41'd128) >> 8);
      wr_plane.dst = dprod[40] ? -drnd[DST_W-1:0] : drnd[DST_W-1:0];
   end

   // cell chain: plane slots, point walks from cell 0 upward
   for (genvar c = 0; c < MAX_SIDES; c++) begin : g_cell
      bpv_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (IDX_W'(c)),
         .wr_en     (wr_en),
         .wr_idx    (plane_cnt_ff[IDX_W-1:0]),
         .wr_plane  (wr_plane),
         .ctl       (ctl),
         .pt_in     ((c == 0) ? inject : chain[(c == 0) ? 0 : c - 1]),
         .pt_out    (chain[c]),
         .plane_out (cell_plane[c])
      );
   end

   bpv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (un_ff),
      .divisor  (det_mag),
      .res      (div_res)
   );

   // sign and clamp of the quotient
   always_comb begin
      if (neg_ff) begin
         q_clamp = (div_res.quot > SAT_NEG) ? SAT_NEG : div_res.quot;
         q_clamp = -q_clamp;
      end else begin
         q_clamp = (div_res.quot > SAT_POS) ? SAT_POS : div_res.quot;
      end
   end

   // sequencer: next state and datapath
   always_comb begin
      state_in     = state_ff;
      plane_cnt_in = plane_cnt_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      emit_cnt_in  = emit_cnt_ff;
      ovf_in       = ovf_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      c23_in       = c23_ff;
      c31_in       = c31_ff;
      c12_in       = c12_ff;
      det_in       = det_ff;
      t_in         = t_ff;
      un_in        = un_ff;
      neg_in       = neg_ff;
      p_in         = p_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      div_start    = 1'b0;
      rd_idx       = i_ff;
      inject.valid   = 1'b0;
      inject.outside = 1'b0;
      inject.p       = p_ff;

      dt0 = $signed(a_ff.nrm[0]) * $signed(c23_ff[0]);
      dt1 = $signed(a_ff.nrm[1]) * $signed(c23_ff[1]);
      dt2 = $signed(a_ff.nrm[2]) * $signed(c23_ff[2]);
      n0  = $signed(quarter(c23_ff[t_ff])) * $signed(a_ff.dst);
      n1  = $signed(quarter(c31_ff[t_ff])) * $signed(b_ff.dst);
      n2  = $signed(quarter(c12_ff[t_ff])) * $signed(c_ff.dst);
      num = n0 + n1 + n2;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (plane_cnt_ff < CNT_W'(MAX_SIDES)) begin
                  wr_en        = 1'b1;
                  plane_cnt_in = plane_cnt_ff + CNT_W'(1);
               end
               if (req_data.last_plane) begin
                  n_in     = plane_cnt_in;
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            emit_cnt_in = '0;
            ovf_in      = 1'b0;
            i_in        = IDX_W'(0);
            j_in        = IDX_W'(1);
            k_in        = IDX_W'(2);
            state_in    = (n_ff < CNT_W'(MIN_PLANES)) ? ST_CLOSE : ST_FI;
         end
         ST_FI: begin
            rd_idx   = i_ff;
            a_in     = rd_plane;
            state_in = ST_FJ;
         end
         ST_FJ: begin
            rd_idx   = j_ff;
            b_in     = rd_plane;
            state_in = ST_FK;
         end
         ST_FK: begin
            rd_idx   = k_ff;
            c_in     = rd_plane;
            state_in = ST_CR;
         end
         ST_CR: begin
            c23_in   = cross3(b_ff.nrm, c_ff.nrm);
            state_in = ST_DET;
         end
         ST_DET: begin
            det_in   = DET_W'(dt0) + DET_W'(dt1) + DET_W'(dt2);
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (det_mag < EPS_Q42) begin
               state_in = ST_NEXT;
            end else begin
               c31_in   = cross3(c_ff.nrm, a_ff.nrm);
               c12_in   = cross3(a_ff.nrm, b_ff.nrm);
               t_in     = 2'd0;
               state_in = ST_NUM;
            end
         end
         ST_NUM: begin
            un_in    = num[NUM_W-1] ? -num : num;
            neg_in   = num[NUM_W-1] != det_ff[DET_W-1];
            state_in = ST_DSTART;
         end
         ST_DSTART: begin
            div_start = 1'b1;
            state_in  = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (div_res.done) begin
               p_in[t_ff] = q_clamp;
               if (t_ff == 2'd2) begin
                  state_in = ST_SCAN_GO;
               end else begin
                  t_in     = t_ff + 2'd1;
                  state_in = ST_NUM;
               end
            end
         end
         ST_SCAN_GO: begin
            inject.valid = 1'b1;
            state_in     = ST_SCAN_WAIT;
         end
         ST_SCAN_WAIT: begin
            if (chain[MAX_SIDES-1].valid) begin
               if (chain[MAX_SIDES-1].outside) begin
                  state_in = ST_NEXT;
               end else if (emit_cnt_ff < VCNT_W'(MAX_VERTS)) begin
                  state_in = ST_EMIT;
               end else begin
                  ovf_in   = 1'b1;
                  state_in = ST_NEXT;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               emit_cnt_in              = emit_cnt_ff + VCNT_W'(1);
               rsp_valid_in             = 1'b1;
               rsp_data_in.vert_x       = p_ff[0];
               rsp_data_in.vert_y       = p_ff[1];
               rsp_data_in.vert_z       = p_ff[2];
               rsp_data_in.is_vertex    = 1'b1;
               rsp_data_in.vertex_count = emit_cnt_in;
               rsp_data_in.overflow     = 1'b0;
               rsp_data_in.last         = 1'b0;
               state_in                 = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (CNT_W'(k_ff) + CNT_W'(1) < n_ff) begin
               k_in     = k_ff + IDX_W'(1);
               state_in = ST_FK;
            end else if (CNT_W'(j_ff) + CNT_W'(2) < n_ff) begin
               j_in     = j_ff + IDX_W'(1);
               k_in     = j_ff + IDX_W'(2);
               state_in = ST_FJ;
            end else if (CNT_W'(i_ff) + CNT_W'(3) < n_ff) begin
               i_in     = i_ff + IDX_W'(1);
               j_in     = i_ff + IDX_W'(2);
               k_in     = i_ff + IDX_W'(3);
               state_in = ST_FI;
            end else begin
               state_in = ST_CLOSE;
            end
         end
         ST_CLOSE: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.vert_x       = '0;
               rsp_data_in.vert_y       = '0;
               rsp_data_in.vert_z       = '0;
               rsp_data_in.is_vertex    = 1'b0;
               rsp_data_in.vertex_count = emit_cnt_ff;
               rsp_data_in.overflow     = ovf_ff;
               rsp_data_in.last         = 1'b1;
               plane_cnt_in             = '0;
               emit_cnt_in              = '0;
               state_in                 = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scale_ff     <= SCALE_RST;
         plane_cnt_ff <= '0;
         emit_cnt_ff  <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         plane_cnt_ff <= plane_cnt_in;
         emit_cnt_ff  <= emit_cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            scale_ff <= csr_wr_data;
         end
      end
   end

   // tolerance = round(scale * 16384 / 10), via reciprocal of ten
   always_ff @(posedge clock) begin
      tol_prod_ff <= 31'({scale_ff, 14'b0} + 30'd5) * 32'hCCCCCCCD;
      tol_ff      <= tol_prod_ff[61:35];
      n_ff        <= n_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      c_ff        <= c_in;
      c23_ff      <= c23_in;
      c31_ff      <= c31_in;
      c12_ff      <= c12_in;
      det_ff      <= det_in;
      t_ff        <= t_in;
      un_ff       <= un_in;
      neg_ff      <= neg_in;
      p_ff        <= p_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/bpv_chk.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bpv_chk: port checker
// Watches the top level's ports; bound to the core below.
// ---------------------------------------------------------------------------
module bpv_chk
   import bpv_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input req_type          req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input rsp_type          rsp_data
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_solve_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.last_plane |=> req_stall)
      else $error("input taken during solve");

   a_close_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> !rsp_data.is_vertex
      && rsp_data.vert_x == 0 && rsp_data.vert_y == 0 && rsp_data.vert_z == 0)
      else $error("bad closing transfer");

   a_vertex_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_vertex |-> !rsp_data.last && !rsp_data.overflow
      && rsp_data.vertex_count != 0)
      else $error("bad vertex transfer");

endmodule

bind brush_plane_vertex_enumerator_core bpv_chk u_bpv_chk (.*);
